>>> src/hmg_pkg.sv
// Shared types and constants for the heat-map grid engine.
package hmg_pkg;

   localparam int CFG_IDX_W = 3;
   localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_STOP0  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_STOP1  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_STOP2  = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_STOP3  = 3'd6;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] x_pos;
      logic [15:0] y_pos;
      logic [30:0] hit_count;
   } req_type;

   typedef struct packed {
      logic [31:0] cell_value;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CENTRE_RD, ST_CENTRE_WAIT, ST_CENTRE_WR,
      ST_DISC_RD, ST_DISC_WAIT, ST_DISC_WR, ST_READ_RD, ST_READ_WAIT,
      ST_DIVIDE, ST_COLOUR, ST_RESPOND
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;   // capture request and bounds
      logic clear_step;  // write zero at clear address, advance
      logic addr_centre; // select centre cell address
      logic addr_disc;   // select disc cursor address
      logic mem_read;
      logic centre_wr;   // write centre cell plus count
      logic disc_wr;     // write disc cell plus one (when in disc)
      logic disc_next;   // advance disc cursor
      logic read_load;   // capture read cell value, start divider
      logic div_step;
      logic colour_load;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic in_grid;
      logic disc_empty;  // radius zero
      logic disc_last;
      logic div_done;
   } sts_type;

endpackage

>>> src/hmg_if.sv
// Valid/ready stream interface carrying a payload.
interface hmg_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/hmg_ram.sv
// Generic single-port RAM with registered read.
module hmg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      if (rd_en) rd_data <= mem[addr];
   end
endmodule

>>> src/hmg_ctrl.sv
// Sequencer for clearing, adds and reads of the heat-map grid.
module hmg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hmg_pkg::cmd_type  cmd,
   input  hmg_pkg::sts_type  sts,
   input  logic              req_op
);
   import hmg_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:       if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid)
               state_in = (req_op == OP_READ) ? ST_READ_RD : ST_CENTRE_RD;
         end
         ST_CENTRE_RD:   state_in = sts.in_grid ? ST_CENTRE_WAIT : ST_IDLE;
         ST_CENTRE_WAIT: state_in = ST_CENTRE_WR;
         ST_CENTRE_WR:   state_in = sts.disc_empty ? ST_IDLE : ST_DISC_RD;
         ST_DISC_RD:     state_in = ST_DISC_WAIT;
         ST_DISC_WAIT:   state_in = ST_DISC_WR;
         ST_DISC_WR:     state_in = sts.disc_last ? ST_IDLE : ST_DISC_RD;
         ST_READ_RD:     state_in = ST_READ_WAIT;
         ST_READ_WAIT:   state_in = ST_DIVIDE;
         ST_DIVIDE:      if (sts.div_done) state_in = ST_COLOUR;
         ST_COLOUR:      state_in = ST_RESPOND;
         ST_RESPOND:     if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:       cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_CENTRE_RD: begin
            cmd.addr_centre = 1'b1;
            cmd.mem_read = 1'b1;
         end
         ST_CENTRE_WAIT: cmd.addr_centre = 1'b1;
         ST_CENTRE_WR: begin
            cmd.addr_centre = 1'b1;
            cmd.centre_wr = 1'b1;
         end
         ST_DISC_RD: begin
            cmd.addr_disc = 1'b1;
            cmd.mem_read = 1'b1;
         end
         ST_DISC_WAIT:   cmd.addr_disc = 1'b1;
         ST_DISC_WR: begin
            cmd.addr_disc = 1'b1;
            cmd.disc_wr = 1'b1;
            cmd.disc_next = 1'b1;
         end
         ST_READ_RD: begin
            cmd.addr_centre = 1'b1;
            cmd.mem_read = 1'b1;
         end
         ST_READ_WAIT:   cmd.read_load = 1'b1;
         ST_DIVIDE:      cmd.div_step = 1'b1;
         ST_COLOUR:      cmd.colour_load = 1'b1;
         ST_RESPOND:     cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default:        cmd = '0;
      endcase
   end

   // Result valid holds until transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

>>> src/hmg_datapath.sv
// Grid memory, disc cursor, divider and colour mixing.
module hmg_datapath #(
   parameter int GRID_COLS = 256,
   parameter int GRID_ROWS = 256,
   parameter int MAX_RADIUS = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  hmg_pkg::cmd_type  cmd,
   output hmg_pkg::sts_type  sts,
   input  hmg_pkg::req_type  req,
   input  logic              csr_we,
   input  logic [hmg_pkg::CFG_IDX_W-1:0] csr_idx,
   input  logic [31:0]       csr_wdata,
   output hmg_pkg::rsp_type  rsp
);
   import hmg_pkg::*;

   localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int DEPTH = GRID_COLS * GRID_ROWS;
   localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
   localparam int RADW = $clog2(MAX_RADIUS + 1);
   localparam int OW = RADW + 2;           // signed offset width
   localparam int SQW = 2 * RADW + 2;      // squared distance width

   // Configuration registers
   logic [8:0]  width_ff, height_ff;
   logic [3:0]  radius_ff;
   logic [23:0] stop_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 9'd256;
         height_ff  <= 9'd256;
         radius_ff  <= 4'd10;
         stop_ff[0] <= 24'h0000FF;
         stop_ff[1] <= 24'h00FF00;
         stop_ff[2] <= 24'hFFFF00;
         stop_ff[3] <= 24'hFF0000;
      end else if (csr_we) begin
         case (csr_idx)
            REG_WIDTH:  width_ff   <= csr_wdata[8:0];
            REG_HEIGHT: height_ff  <= csr_wdata[8:0];
            REG_RADIUS: radius_ff  <= csr_wdata[3:0];
            REG_STOP0:  stop_ff[0] <= csr_wdata[23:0];
            REG_STOP1:  stop_ff[1] <= csr_wdata[23:0];
            REG_STOP2:  stop_ff[2] <= csr_wdata[23:0];
            REG_STOP3:  stop_ff[3] <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Effective extent and radius, computed at capture
   logic [12:0] eff_w, eff_h;
   logic [5:0]  eff_r;
   assign eff_w = ({4'd0, width_ff} > 13'(GRID_COLS)) ? 13'(GRID_COLS) : {4'd0, width_ff};
   assign eff_h = ({4'd0, height_ff} > 13'(GRID_ROWS)) ? 13'(GRID_ROWS) : {4'd0, height_ff};
   assign eff_r = ({2'd0, radius_ff} > 6'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : {2'd0, radius_ff};

   logic [CW-1:0]   px_ff;
   logic [RW-1:0]   py_ff;
   logic [30:0]     cnt_ff;
   logic            inside_ff;
   logic [12:0]     w_ff, h_ff;
   logic [RADW-1:0] r_ff;
   logic signed [OW-1:0] dx_ff, dy_ff;
   logic            inside_in;

   assign inside_in = ({1'b0, req.x_pos} < {4'd0, eff_w}) &&
                      ({1'b0, req.y_pos} < {4'd0, eff_h});

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         px_ff     <= req.x_pos[CW-1:0];
         py_ff     <= req.y_pos[RW-1:0];
         cnt_ff    <= req.hit_count;
         inside_ff <= inside_in;
         w_ff      <= eff_w;
         h_ff      <= eff_h;
         r_ff      <= eff_r[RADW-1:0];
         dx_ff     <= -OW'($signed({1'b0, eff_r[RADW-1:0]}));
         dy_ff     <= -OW'($signed({1'b0, eff_r[RADW-1:0]}));
      end else if (cmd.disc_next) begin
         if (dy_ff == OW'(r_ff) - OW'(1)) begin
            dy_ff <= -OW'($signed({1'b0, r_ff}));
            dx_ff <= dx_ff + OW'(1);
         end else begin
            dy_ff <= dy_ff + OW'(1);
         end
      end
   end

   // Disc cursor cell and membership
   logic signed [14:0] cx, cy;
   logic [SQW-1:0] dsq, rsq;
   logic in_disc;
   assign cx  = $signed({2'b00, 13'(px_ff)}) + 15'(dx_ff);
   assign cy  = $signed({2'b00, 13'(py_ff)}) + 15'(dy_ff);
   assign dsq = SQW'(SQW'(dx_ff) * SQW'(dx_ff)) + SQW'(SQW'(dy_ff) * SQW'(dy_ff));
   assign rsq = SQW'(r_ff) * SQW'(r_ff);
   assign in_disc = (dsq <= rsq) && !cx[14] && !cy[14] &&
                    (cx[13:0] < {1'b0, w_ff}) && (cy[13:0] < {1'b0, h_ff});

   // Memory address and clear sweep
   logic [AW:0]   clr_ff;
   logic [AW-1:0] addr;
   logic [AW-1:0] centre_addr, disc_addr;
   assign centre_addr = AW'(py_ff) * AW'(GRID_COLS) + AW'(px_ff);
   assign disc_addr   = AW'(cy[13:0]) * AW'(GRID_COLS) + AW'(cx[13:0]);

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step && !clr_ff[AW]) clr_ff <= clr_ff + 1'b1;
   end

   always_comb begin
      addr = clr_ff[AW-1:0];
      if (cmd.addr_centre) addr = centre_addr;
      else if (cmd.addr_disc) addr = disc_addr;
   end

   logic [31:0] rd_data, wr_data, sum_base;
   logic [32:0] sum;
   logic        wr_en;
   assign sum_base = cmd.centre_wr ? {1'b0, cnt_ff} : 32'd1;
   assign sum      = {1'b0, rd_data} + {1'b0, sum_base};
   assign wr_data  = cmd.clear_step ? 32'd0 : (sum[32] ? 32'hFFFFFFFF : sum[31:0]);
   assign wr_en    = (cmd.clear_step && !clr_ff[AW]) || cmd.centre_wr ||
                     (cmd.disc_wr && in_disc);

   hmg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (cmd.mem_read),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Running peak
   logic [31:0] peak_ff;
   always_ff @(posedge clock) begin
      if (reset) peak_ff <= '0;
      else if ((cmd.centre_wr || (cmd.disc_wr && in_disc)) && wr_data > peak_ff)
         peak_ff <= wr_data;
   end

   // Restoring divider: t = cell*768 / peak, one quotient bit per cycle
   logic [31:0] cell_ff;
   logic [41:0] dvd_ff;     // dividend bits shifting out
   logic [42:0] rem_ff;
   logic [41:0] quo_ff;
   logic [5:0]  dcnt_ff;
   logic [42:0] rem_sh;
   logic [31:0] cell_rd;
   assign cell_rd = inside_ff ? rd_data : 32'd0;
   assign rem_sh  = {rem_ff[41:0], dvd_ff[41]};

   always_ff @(posedge clock) begin
      if (cmd.read_load) begin
         cell_ff <= cell_rd;
         dvd_ff  <= {1'b0, cell_rd, 9'd0} + {2'd0, cell_rd, 8'd0}; // cell*512 + cell*256
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= 6'd42;
      end else if (cmd.div_step && dcnt_ff != 6'd0) begin
         dvd_ff  <= {dvd_ff[40:0], 1'b0};
         dcnt_ff <= dcnt_ff - 6'd1;
         if (rem_sh >= {11'd0, peak_ff}) begin
            rem_ff <= rem_sh - {11'd0, peak_ff};
            quo_ff <= {quo_ff[40:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[40:0], 1'b0};
         end
      end
   end

   // Colour selection and mixing
   logic [7:0]  f_ff;
   logic [23:0] c1_ff, c2_ff;
   logic [41:0] t;
   assign t = quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.colour_load) begin
         if (cell_ff == 32'd0 || peak_ff == 32'd0) begin
            c1_ff <= stop_ff[0]; c2_ff <= stop_ff[0]; f_ff <= 8'd0;
         end else if (t >= 42'd768) begin
            c1_ff <= stop_ff[3]; c2_ff <= stop_ff[3]; f_ff <= 8'd0;
         end else begin
            c1_ff <= stop_ff[t[9:8]];
            c2_ff <= stop_ff[t[9:8] + 2'd1];
            f_ff  <= t[7:0];
         end
      end
   end

   function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] f);
      logic [16:0] acc;
      acc = 17'(a) * (17'd256 - 17'(f)) + 17'(b) * 17'(f);
      return acc[15:8];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp.cell_value <= cell_ff;
         rsp.red   <= mix(c1_ff[23:16], c2_ff[23:16], f_ff);
         rsp.green <= mix(c1_ff[15:8],  c2_ff[15:8],  f_ff);
         rsp.blue  <= mix(c1_ff[7:0],   c2_ff[7:0],   f_ff);
      end
   end

   assign sts.clear_done = clr_ff[AW];
   assign sts.in_grid    = inside_ff;
   assign sts.disc_empty = (r_ff == '0);
   assign sts.disc_last  = (dx_ff == OW'(r_ff) - OW'(1)) && (dy_ff == OW'(r_ff) - OW'(1));
   assign sts.div_done   = (dcnt_ff == 6'd0);
endmodule

>>> src/heatmap_disc_splat_color_grid.sv
// Top level of the heat-map grid engine.
// Heat-map grid engine: a grid of saturating 32-bit counters in one single-port
// RAM. After reset a clearing pass writes zero to every cell, during which no
// request is taken; configuration writes are taken at any time. An add that
// lands inside the grid adds the count to the centre cell, then steps through
// each cell of the (2r)^2 square around it and adds one to those in the disc;
// each step is a read-modify-write on the one RAM port. An add outside the grid
// changes no cell. A read runs through the bit-serial divider that forms the
// gradient position.
module heatmap_disc_splat_color_grid #(
   parameter int GRID_COLS  = 256,
   parameter int GRID_ROWS  = 256,
   parameter int MAX_RADIUS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_x_pos,
   input  logic [15:0] req_y_pos,
   input  logic [30:0] req_hit_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_cell_value,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [hmg_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import hmg_pkg::*;

   hmg_if #(.W($bits(req_type))) req_ch ();
   hmg_if #(.W($bits(rsp_type))) rsp_ch ();

   cmd_type cmd;
   sts_type sts;
   req_type req_pl;
   rsp_type rsp_pl;

   assign req_ch.valid = req_valid;
   assign req_ch.data  = {req_op, req_x_pos, req_y_pos, req_hit_count};
   assign req_ready    = req_ch.ready;
   assign req_pl       = req_ch.data;

   assign rsp_ch.data    = rsp_pl;
   assign rsp_ch.ready   = rsp_ready;
   assign rsp_valid      = rsp_ch.valid;
   assign rsp_cell_value = rsp_ch.data[55:24];
   assign rsp_red        = rsp_ch.data[23:16];
   assign rsp_green      = rsp_ch.data[15:8];
   assign rsp_blue       = rsp_ch.data[7:0];

   assign csr_ready = 1'b1;

   hmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts),
      .req_op    (req_pl.op)
   );

   hmg_datapath #(
      .GRID_COLS  (GRID_COLS),
      .GRID_ROWS  (GRID_ROWS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req       (req_pl),
      .csr_we    (csr_valid),
      .csr_idx   (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_pl)
   );
endmodule
